[hdl/swfp_pkg.sv]
// shared types, character codes and unit codes for the scale weight frame parser
// no dependencies; used by every module in hdl/
package swfp_pkg;

	// frame geometry
	localparam int WinLen   = 18;
	localparam int TxtFirst = 7;
	localparam int TxtLen   = 7;
	localparam int CntW     = $clog2(WinLen + 1);

	// character codes
	localparam logic [7:0] CharCr    = 8'd13;
	localparam logic [7:0] CharLf    = 8'd10;
	localparam logic [7:0] CharComma = 8'h2C;
	localparam logic [7:0] CharMinus = 8'h2D;
	localparam logic [7:0] CharPoint = 8'h2E;
	localparam logic [7:0] CharSpace = 8'h20;
	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharNine  = 8'h39;
	localparam logic [7:0] CharG     = 8'h67;
	localparam logic [7:0] CharK     = 8'h6B;
	localparam logic [7:0] CharL     = 8'h6C;
	localparam logic [7:0] CharB     = 8'h62;
	localparam logic [7:0] CharO     = 8'h6F;
	localparam logic [7:0] CharZ     = 8'h7A;

	// unit codes as presented on unit_code
	localparam logic [1:0] UnitKg = 2'd0;
	localparam logic [1:0] UnitG  = 2'd1;
	localparam logic [1:0] UnitLb = 2'd2;
	localparam logic [1:0] UnitOz = 2'd3;

	localparam int MantW = 24;
	localparam int DecW  = 3;

	// byte window, index 0 is the oldest byte
	typedef logic [WinLen-1:0][7:0] win_t;

	// decoded frame contents
	typedef struct packed {
		logic             ok;
		logic             neg;
		logic [MantW-1:0] mant;
		logic [DecW-1:0]  decs;
		logic [1:0]       unit;
	} parse_t;

endpackage

[hdl/swfp_window.sv]
// sliding byte window, fill count and frame detection
// depends on swfp_pkg
module swfp_window (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic                drain,
	input  logic [7:0]          rx_byte,
	output swfp_pkg::win_t      win_s1,
	output logic                frame_s1
);

	logic [swfp_pkg::CntW-1:0] cnt_q;
	logic [swfp_pkg::CntW-1:0] cnt_next;
	swfp_pkg::win_t            win_next;
	logic                      hit;

	// shifted window and frame check on the bytes as they will stand
	always_comb begin
		win_next = {rx_byte, win_s1[swfp_pkg::WinLen-1:1]};
		if (cnt_q == swfp_pkg::CntW'(swfp_pkg::WinLen)) begin
			cnt_next = cnt_q;
		end else begin
			cnt_next = cnt_q + 1'b1;
		end
		hit = (cnt_next == swfp_pkg::CntW'(swfp_pkg::WinLen))
			&& (win_next[2] == swfp_pkg::CharComma)
			&& (win_next[5] == swfp_pkg::CharComma)
			&& (win_next[16] == swfp_pkg::CharCr)
			&& (win_next[17] == swfp_pkg::CharLf);
	end

	// shift line, payload only
	always_ff @(posedge clk) begin
		if (take) begin
			win_s1 <= win_next;
		end
	end

	// fill count and pending frame flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			frame_s1 <= 1'b0;
		end else begin
			if (take) begin
				cnt_q    <= hit ? '0 : cnt_next;
				frame_s1 <= hit;
			end else if (drain) begin
				frame_s1 <= 1'b0;
			end
		end
	end

endmodule

[hdl/swfp_parse.sv]
// decodes sign, weight text and unit from a complete frame
// depends on swfp_pkg
module swfp_parse (
	input  swfp_pkg::win_t  win,
	output swfp_pkg::parse_t res
);

	logic [swfp_pkg::TxtLen-1:0]      sp;
	logic [swfp_pkg::TxtLen-1:0]      dig;
	logic [swfp_pkg::TxtLen-1:0]      pt;
	logic [swfp_pkg::TxtLen-1:0]      lead;
	logic [swfp_pkg::TxtLen-1:0]      trail;
	logic [swfp_pkg::TxtLen-1:0]      inner;
	logic [swfp_pkg::TxtLen-1:0]      pt_before;
	logic [swfp_pkg::TxtLen-1:0]      pt_in;
	logic [swfp_pkg::MantW-1:0]       m;
	logic [swfp_pkg::DecW-1:0]        d;
	logic [7:0]                       c;
	logic [7:0]                       u0;
	logic [7:0]                       u1;
	logic [1:0]                       unit_sel;

	// character classes
	always_comb begin
		for (int k = 0; k < swfp_pkg::TxtLen; k++) begin
			c      = win[swfp_pkg::TxtFirst + k];
			sp[k]  = (c == swfp_pkg::CharSpace);
			dig[k] = (c >= swfp_pkg::CharZero) && (c <= swfp_pkg::CharNine);
			pt[k]  = (c == swfp_pkg::CharPoint);
		end
	end

	// leading and trailing space runs, point position
	always_comb begin
		lead[0]      = sp[0];
		pt_before[0] = 1'b0;
		for (int k = 1; k < swfp_pkg::TxtLen; k++) begin
			lead[k]      = lead[k-1] & sp[k];
			pt_before[k] = pt_before[k-1] | pt[k-1];
		end
		trail[swfp_pkg::TxtLen-1] = sp[swfp_pkg::TxtLen-1];
		for (int k = swfp_pkg::TxtLen - 2; k >= 0; k--) begin
			trail[k] = trail[k+1] & sp[k];
		end
		inner = ~lead & ~trail;
	end

	// mantissa by decimal shift-add, decimals by counting digits after the point
	always_comb begin
		m = '0;
		d = '0;
		for (int k = 0; k < swfp_pkg::TxtLen; k++) begin
			if (dig[k]) begin
				m = (m << 3) + (m << 1)
					+ {{(swfp_pkg::MantW-4){1'b0}}, win[swfp_pkg::TxtFirst + k][3:0]};
				if (pt_before[k]) begin
					d = d + 1'b1;
				end
			end
		end
	end

	// unit bytes
	always_comb begin
		u0 = win[14];
		u1 = win[15];
		if (u0 == swfp_pkg::CharSpace && u1 == swfp_pkg::CharG) begin
			unit_sel = swfp_pkg::UnitG;
		end else if (u0 == swfp_pkg::CharL && u1 == swfp_pkg::CharB) begin
			unit_sel = swfp_pkg::UnitLb;
		end else if (u0 == swfp_pkg::CharO && u1 == swfp_pkg::CharZ) begin
			unit_sel = swfp_pkg::UnitOz;
		end else begin
			unit_sel = swfp_pkg::UnitKg;
		end
	end

	// points between the space runs
	assign pt_in = inner & pt;

	// text valid: only digits and at most one point between the space runs, and a digit
	always_comb begin
		res.ok   = ~|(inner & ~dig & ~pt) && ~|(pt_in & (pt_in - 1'b1)) && |dig;
		res.neg  = (win[6] == swfp_pkg::CharMinus);
		res.mant = m;
		res.decs = d;
		res.unit = unit_sel;
	end

endmodule

[hdl/scale_weight_frame_parser.sv]
// Scale weight frame parser: takes one serial byte per cycle from an electronic
// scale while in_stall is low and presents one weight result (sign, mantissa,
// decimal places, unit) for every 18-byte frame whose weight text is a valid
// number. A byte is taken in each cycle with in_valid high and in_stall low;
// the frame's last byte (LF) lands in the window register when it is accepted,
// the frame is decoded combinationally from there and loaded into the output
// register once that register is free to take it. in_stall rises only while a
// frame with a valid number sits in the window stage and the output register
// holds a result that is stalled; there is no clearing pass after reset.
// depends on swfp_pkg, swfp_window, swfp_parse
module scale_weight_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_negative,
	output logic [23:0] mantissa,
	output logic [2:0]  decimals,
	output logic [1:0]  unit_code
);

	swfp_pkg::win_t   win_s1;
	swfp_pkg::parse_t res;
	logic             frame_s1;
	logic             adv;
	logic             take;
	logic             take_out;
	logic             load;

	// handshake control
	assign take_out = out_valid && !out_stall;
	assign adv      = !frame_s1 || !res.ok || !out_valid || !out_stall;
	assign in_stall = !adv;
	assign take     = in_valid && !in_stall;
	assign load     = frame_s1 && res.ok && adv;

	swfp_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.drain    (adv),
		.rx_byte  (rx_byte),
		.win_s1   (win_s1),
		.frame_s1 (frame_s1)
	);

	swfp_parse u_parse (
		.win (win_s1),
		.res (res)
	);

	// result register, payload
	always_ff @(posedge clk) begin
		if (load) begin
			is_negative <= res.neg;
			mantissa    <= res.mant;
			decimals    <= res.decs;
			unit_code   <= res.unit;
		end
	end

	// result register, valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
			end else if (take_out) begin
				out_valid <= 1'b0;
			end
		end
	end

	// a held frame stays pending until the output side frees up
	assert property (@(posedge clk) disable iff (!arst_n)
		frame_s1 && !adv |=> frame_s1)
		else $error("pending frame dropped while output stalled");

	// the input only stalls behind a decoded frame
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> frame_s1 && out_valid)
		else $error("input stalled without a waiting frame");

	// a loaded result is presented and in range
	assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid && decimals <= 3'd6 && mantissa <= 24'd9999999)
		else $error("loaded result missing or out of range");

endmodule

[tb/sv/scale_weight_frame_parser_test.sv]
`timescale 1ns / 100ps
// testbench for the scale weight frame parser: byte-stream stimulus, weight predictor
// and scoreboard checking every result transaction; depends on swfp_pkg and the rtl

// byte positions inside an 18-byte frame
localparam int PosCommaA = 2;
localparam int PosCommaB = 5;
localparam int PosSign   = 6;
localparam int PosUnit   = 14;
localparam int PosCr     = 16;
localparam int PosLf     = 17;

typedef struct packed {
	logic                       neg;
	logic [swfp_pkg::MantW-1:0] mant;
	logic [swfp_pkg::DecW-1:0]  decs;
	logic [1:0]                 unit;
} weight_t;

// predicts weight results from accepted bytes and checks the block's results
class weight_scoreboard;
	bit [7:0] win [swfp_pkg::WinLen];
	int       fill;
	int       errors;
	weight_t  expected_q [$];

	task report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	function int pending();
		return expected_q.size();
	endfunction

	// slide the window and decode a frame when one completes
	function void note_byte(input bit [7:0] b);
		weight_t     w;
		int          lo;
		int          hi;
		int          ndig;
		int unsigned m;
		int unsigned d;
		bit          seen_point;
		bit          ok;
		bit [7:0]    c;
		if (fill >= swfp_pkg::WinLen) begin
			for (int i = 0; i < swfp_pkg::WinLen - 1; i++)
				win[i] = win[i + 1];
			win[swfp_pkg::WinLen - 1] = b;
		end else begin
			win[fill] = b;
			fill++;
		end
		if (fill < swfp_pkg::WinLen)
			return;
		if (win[PosCommaA] != swfp_pkg::CharComma || win[PosCommaB] != swfp_pkg::CharComma ||
		    win[PosCr] != swfp_pkg::CharCr || win[PosLf] != swfp_pkg::CharLf)
			return;

		// frame found: consumed whole whatever its content
		fill = 0;
		w.neg = (win[PosSign] == swfp_pkg::CharMinus);
		if (win[PosUnit] == swfp_pkg::CharSpace && win[PosUnit + 1] == swfp_pkg::CharG)
			w.unit = swfp_pkg::UnitG;
		else if (win[PosUnit] == swfp_pkg::CharK && win[PosUnit + 1] == swfp_pkg::CharG)
			w.unit = swfp_pkg::UnitKg;
		else if (win[PosUnit] == swfp_pkg::CharL && win[PosUnit + 1] == swfp_pkg::CharB)
			w.unit = swfp_pkg::UnitLb;
		else if (win[PosUnit] == swfp_pkg::CharO && win[PosUnit + 1] == swfp_pkg::CharZ)
			w.unit = swfp_pkg::UnitOz;
		else
			w.unit = swfp_pkg::UnitKg;

		// trim spaces, then digits with at most one point
		lo = swfp_pkg::TxtFirst;
		hi = swfp_pkg::TxtFirst + swfp_pkg::TxtLen - 1;
		while (lo <= hi && win[lo] == swfp_pkg::CharSpace) lo++;
		while (hi >= lo && win[hi] == swfp_pkg::CharSpace) hi--;
		ok = 1'b1;
		m = 0;
		d = 0;
		ndig = 0;
		seen_point = 1'b0;
		for (int i = lo; i <= hi; i++) begin
			c = win[i];
			if (c >= swfp_pkg::CharZero && c <= swfp_pkg::CharNine) begin
				m = m * 10 + (c - swfp_pkg::CharZero);
				ndig++;
				if (seen_point)
					d++;
			end else if (c == swfp_pkg::CharPoint && !seen_point) begin
				seen_point = 1'b1;
			end else begin
				ok = 1'b0;
			end
		end
		if (!ok || ndig == 0)
			return;
		w.mant = m[swfp_pkg::MantW-1:0];
		w.decs = d[swfp_pkg::DecW-1:0];
		expected_q.push_back(w);
	endfunction

	// compare one result transaction with the oldest expectation
	task check_weight(input weight_t got);
		weight_t want;
		if (expected_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result neg %0d mant %0d dec %0d unit %0d",
				got.neg, got.mant, got.decs, got.unit));
			return;
		end
		want = expected_q.pop_front();
		if (got.neg !== want.neg)
			report_mismatch($sformatf("is_negative got %0d want %0d", got.neg, want.neg));
		if (got.mant !== want.mant)
			report_mismatch($sformatf("mantissa got %0d want %0d", got.mant, want.mant));
		if (got.decs !== want.decs)
			report_mismatch($sformatf("decimals got %0d want %0d", got.decs, want.decs));
		if (got.unit !== want.unit)
			report_mismatch($sformatf("unit_code got %0d want %0d", got.unit, want.unit));
	endtask

	task flush_leftovers();
		weight_t want;
		while (expected_q.size() != 0) begin
			want = expected_q.pop_front();
			report_mismatch($sformatf("missing result neg %0d mant %0d dec %0d unit %0d",
				want.neg, want.mant, want.decs, want.unit));
		end
	endtask
endclass

module scale_weight_frame_parser_test;
	localparam int TotalBytes = 1800;
	localparam int CalmFrom   = 1550;
	localparam int PressureAt = 600;
	localparam int HoldCycles = 300;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  rx_byte   = 8'h00;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic        is_negative;
	logic [23:0] mantissa;
	logic [2:0]  decimals;
	logic [1:0]  unit_code;

	weight_scoreboard sb = new();
	bit [7:0] frame_q [$];
	bit [7:0] nul_txt [swfp_pkg::TxtLen];
	bit [7:0] raw_txt [swfp_pkg::TxtLen];
	int       sent_bytes;
	int       idle_pct;
	int       hold_request;
	int       hold_left;
	int       burst_left;
	int       guard;
	int       r;
	bit       calm;
	bit       pressure_done;

	scale_weight_frame_parser uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.is_negative(is_negative),
		.mantissa   (mantissa),
		.decimals   (decimals),
		.unit_code  (unit_code)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// hard limit on run length
	initial begin
		#8000000;
		$display("tb: failure");
		$finish;
	end

	// offer one byte and hold it until the transaction completes
	task automatic send_byte(input bit [7:0] b);
		rx_byte  <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_byte(b);
		sent_bytes++;
		if (!calm && $urandom_range(1, 100) <= idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic build_frame(input bit [7:0] sign, input bit [7:0] txt [swfp_pkg::TxtLen],
	                           input bit [7:0] u0, input bit [7:0] u1);
		frame_q = {};
		frame_q.push_back(8'($urandom_range(0, 255)));
		frame_q.push_back(8'($urandom_range(0, 255)));
		frame_q.push_back(swfp_pkg::CharComma);
		frame_q.push_back(8'($urandom_range(0, 255)));
		frame_q.push_back(8'($urandom_range(0, 255)));
		frame_q.push_back(swfp_pkg::CharComma);
		frame_q.push_back(sign);
		for (int i = 0; i < swfp_pkg::TxtLen; i++)
			frame_q.push_back(txt[i]);
		frame_q.push_back(u0);
		frame_q.push_back(u1);
		frame_q.push_back(swfp_pkg::CharCr);
		frame_q.push_back(swfp_pkg::CharLf);
	endtask

	task automatic send_frame_q();
		foreach (frame_q[i])
			send_byte(frame_q[i]);
	endtask

	task automatic send_text_frame(input bit [7:0] sign, input string txt, input string unit);
		bit [7:0] t [swfp_pkg::TxtLen];
		for (int i = 0; i < swfp_pkg::TxtLen; i++)
			t[i] = txt[i];
		build_frame(sign, t, unit[0], unit[1]);
		send_frame_q();
	endtask

	// random weight text, optionally spoilt
	function automatic void make_text(input bit spoil, output bit [7:0] t [swfp_pkg::TxtLen]);
		bit [7:0] body [$];
		int       ndig;
		int       pt;
		int       left;
		int       mode;
		ndig = $urandom_range(1, swfp_pkg::TxtLen);
		mode = $urandom_range(0, 5);
		pt = (ndig < swfp_pkg::TxtLen && $urandom_range(0, 1)) ? $urandom_range(0, ndig) : -1;
		for (int i = 0; i < ndig; i++)
			body.push_back(mode == 0 ? swfp_pkg::CharNine :
			               mode == 1 ? swfp_pkg::CharZero :
			               8'(swfp_pkg::CharZero + $urandom_range(0, 9)));
		if (pt >= 0)
			body.insert(pt, swfp_pkg::CharPoint);
		left = $urandom_range(0, swfp_pkg::TxtLen - body.size());
		for (int i = 0; i < swfp_pkg::TxtLen; i++)
			t[i] = swfp_pkg::CharSpace;
		foreach (body[i])
			t[left + i] = body[i];
		if (spoil) begin
			case ($urandom_range(0, 3))
				0: t[$urandom_range(0, swfp_pkg::TxtLen - 1)] = 8'($urandom_range(0, 255));
				1: t[$urandom_range(1, swfp_pkg::TxtLen - 2)] = swfp_pkg::CharSpace;
				2: t[$urandom_range(0, swfp_pkg::TxtLen - 1)] = swfp_pkg::CharPoint;
				default: begin
					for (int i = 0; i < swfp_pkg::TxtLen; i++)
						t[i] = swfp_pkg::CharSpace;
				end
			endcase
		end
	endfunction

	task automatic random_frame(input bit spoil, input bit break_marker);
		bit [7:0] t [swfp_pkg::TxtLen];
		bit [7:0] sign;
		bit [7:0] u0;
		bit [7:0] u1;
		int       marks [4];
		marks = '{PosCommaA, PosCommaB, PosCr, PosLf};
		make_text(spoil, t);
		case ($urandom_range(0, 3))
			0: sign = swfp_pkg::CharMinus;
			1: sign = "+";
			2: sign = swfp_pkg::CharSpace;
			default: sign = 8'($urandom_range(0, 255));
		endcase
		case ($urandom_range(0, 4))
			0: begin u0 = swfp_pkg::CharSpace; u1 = swfp_pkg::CharG; end
			1: begin u0 = swfp_pkg::CharK;     u1 = swfp_pkg::CharG; end
			2: begin u0 = swfp_pkg::CharL;     u1 = swfp_pkg::CharB; end
			3: begin u0 = swfp_pkg::CharO;     u1 = swfp_pkg::CharZ; end
			default: begin
				u0 = 8'($urandom_range(0, 255));
				u1 = 8'($urandom_range(0, 255));
			end
		endcase
		build_frame(sign, t, u0, u1);
		if (break_marker)
			frame_q[marks[$urandom_range(0, 3)]] = 8'($urandom_range(0, 255));
		send_frame_q();
	endtask

	// result side: check accepted transactions, stall in bursts or long hold-offs
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_weight('{is_negative, mantissa, decimals, unit_code});
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left--;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			burst_left = $urandom_range(1, 6) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// stimulus
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames: units, point placement, sign cases, bad text
		idle_pct = 20;
		send_text_frame("+", "   12.5", "kg");
		send_text_frame(swfp_pkg::CharMinus, "  0.000", "kg");
		send_text_frame(swfp_pkg::CharSpace, ".5     ", " g");
		send_text_frame("+", "5.     ", "lb");
		send_text_frame("+", "9999999", "oz");
		send_text_frame(swfp_pkg::CharMinus, ".999999", "xy");
		send_text_frame("+", "1 2    ", "kg");
		send_text_frame("+", "       ", "oz");
		send_text_frame("+", "   .   ", "kg");
		send_text_frame("+", "1.2.3  ", " g");
		nul_txt = '{"1", 8'h00, "2", "3", " ", " ", " "};
		build_frame(swfp_pkg::CharMinus, nul_txt, swfp_pkg::CharK, swfp_pkg::CharG);
		send_frame_q();
		raw_txt = '{"0", "0", "0", "0", "0", "0", "1"};
		build_frame(8'hFF, raw_txt, 8'h01, 8'hFF);
		send_frame_q();
		// noise with extreme bytes, then a frame that has to be found by sliding
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(swfp_pkg::CharComma);
		send_byte(swfp_pkg::CharCr);
		send_byte(swfp_pkg::CharLf);
		send_text_frame("+", "  42   ", "lb");
		random_frame(1'b0, 1'b1);
		send_text_frame("+", "7      ", "gk");

		// random part: mostly frames, some broken frames and noise
		while (sent_bytes < TotalBytes) begin
			if (sent_bytes >= CalmFrom)
				calm = 1'b1;
			if (!pressure_done && sent_bytes >= PressureAt) begin
				// receiver holds off while good frames keep coming
				idle_pct = 0;
				hold_request = HoldCycles;
				repeat (6) random_frame(1'b0, 1'b0);
				pressure_done = 1'b1;
			end
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 10;
				default: idle_pct = 30;
			endcase
			r = $urandom_range(0, 99);
			if (r < 70)
				random_frame($urandom_range(0, 3) == 0, 1'b0);
			else if (r < 82)
				random_frame(1'b0, 1'b1);
			else
				repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(0, 255)));
		end
		in_valid <= 1'b0;

		// drain outstanding results, then allow for pipeline latency
		guard = 0;
		while (sb.pending() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		sb.flush_leftovers();
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

[sim.f]
hdl/swfp_pkg.sv
hdl/swfp_window.sv
hdl/swfp_parse.sv
hdl/scale_weight_frame_parser.sv
tb/sv/scale_weight_frame_parser_test.sv
